// ----- sv/smm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and codes for the slice marker spacing merge block.
// No dependencies; every other file imports this package.
package smm_pkg;

  localparam int FRAME_WIDTH = 32;
  localparam int CONF_WIDTH  = 16;
  localparam int SRC_WIDTH   = 3;
  localparam int INDEX_WIDTH = 32;
  localparam int PRIO_WIDTH  = 3;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 32;

  // Input payload: frame, confidence, source, valid, padded to whole bytes.
  localparam int IN_FIELDS_WIDTH = FRAME_WIDTH + CONF_WIDTH + SRC_WIDTH + 1;
  localparam int IN_DATA_WIDTH   = ((IN_FIELDS_WIDTH + 7) / 8) * 8;
  // Output payload: start, end, marker index, confidence, source.
  localparam int OUT_FIELDS_WIDTH = 2 * FRAME_WIDTH + INDEX_WIDTH + CONF_WIDTH + SRC_WIDTH;
  localparam int OUT_DATA_WIDTH   = ((OUT_FIELDS_WIDTH + 7) / 8) * 8;

  localparam logic [CONF_WIDTH-1:0]  CONF_ONE      = CONF_WIDTH'(4096);
  localparam logic [INDEX_WIDTH-1:0] INDEX_MAX     = '1;

  typedef enum logic [SRC_WIDTH-1:0] {
    SRC_LOOP_START = 3'd0,
    SRC_LOOP_END   = 3'd1,
    SRC_MANUAL     = 3'd2,
    SRC_IMPORTED   = 3'd3,
    SRC_BEAT_GRID  = 3'd4,
    SRC_SILENCE    = 3'd5,
    SRC_ONSET      = 3'd6
  } src_code_t;

  typedef enum logic {
    CMD_CANDIDATE = 1'b0,
    CMD_FINISH    = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MIN_SPACING   = 1'b0,
    REG_SOURCE_LENGTH = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                   cmd;
    logic [FRAME_WIDTH-1:0] frame;
    logic [CONF_WIDTH-1:0]  conf;
    logic [SRC_WIDTH-1:0]   src;
    logic                   valid;
  } cand_t;

  typedef struct packed {
    logic [FRAME_WIDTH-1:0] frame;
    logic [CONF_WIDTH-1:0]  conf;
    logic [SRC_WIDTH-1:0]   src;
    logic [INDEX_WIDTH-1:0] index;
  } kept_t;

  typedef struct packed {
    logic [FRAME_WIDTH-1:0] open_frame;
    logic [FRAME_WIDTH-1:0] close_frame;
    logic [INDEX_WIDTH-1:0] marker;
    logic [CONF_WIDTH-1:0]  conf;
    logic [SRC_WIDTH-1:0]   src;
    logic                   done;
  } region_t;

  localparam kept_t KEPT_ORIGIN = '{
    frame: '0,
    conf:  CONF_ONE,
    src:   SRC_MANUAL,
    index: '0
  };

  // Higher value means the source is trusted more; code 7 is unused.
  function automatic logic [PRIO_WIDTH-1:0] source_priority(input logic [SRC_WIDTH-1:0] s);
    logic [PRIO_WIDTH-1:0] p;
    case (s)
      SRC_LOOP_START, SRC_LOOP_END: p = PRIO_WIDTH'(5);
      SRC_MANUAL, SRC_IMPORTED:     p = PRIO_WIDTH'(4);
      SRC_BEAT_GRID:                p = PRIO_WIDTH'(3);
      SRC_SILENCE:                  p = PRIO_WIDTH'(2);
      SRC_ONSET:                    p = PRIO_WIDTH'(1);
      default:                      p = '0;
    endcase
    return p;
  endfunction

endpackage

// ----- sv/smm_merge.sv -----
`timescale 1ns / 1ps
// Per-item decision logic: compares one candidate against the kept marker
// and yields the next kept marker and an optional region. Uses smm_pkg.
module smm_merge (
  input  smm_pkg::cand_t                       cand,
  input  smm_pkg::kept_t                       kept,
  input  logic [smm_pkg::FRAME_WIDTH-1:0]      min_gap,
  input  logic [smm_pkg::FRAME_WIDTH-1:0]      source_length,
  output smm_pkg::kept_t                       kept_next,
  output logic                                 emit,
  output smm_pkg::region_t                     region
);
  import smm_pkg::*;

  logic [FRAME_WIDTH-1:0] distance;
  logic                   dropped;
  logic                   close;
  logic                   better;

  assign distance = cand.frame - kept.frame;
  assign close    = distance < min_gap;
  assign dropped  = !cand.valid || (cand.frame == '0) || (cand.frame >= source_length);

  always_comb begin
    if (cand.conf != kept.conf) begin
      better = cand.conf > kept.conf;
    end else begin
      better = source_priority(cand.src) > source_priority(kept.src);
    end
  end

  always_comb begin
    kept_next          = kept;
    emit               = 1'b0;
    region.open_frame  = kept.frame;
    region.close_frame = cand.frame;
    region.marker      = kept.index;
    region.conf        = kept.conf;
    region.src         = kept.src;
    region.done        = 1'b0;
    if (cand.cmd == CMD_FINISH) begin
      region.close_frame = source_length;
      region.done        = 1'b1;
      emit               = source_length > kept.frame;
      kept_next          = KEPT_ORIGIN;
    end else if (!dropped) begin
      if (close) begin
        // The origin marker is never replaced by a nearby candidate.
        if ((kept.frame != '0) && better) begin
          kept_next.frame = cand.frame;
          kept_next.conf  = cand.conf;
          kept_next.src   = cand.src;
        end
      end else begin
        emit            = cand.frame > kept.frame;
        kept_next.frame = cand.frame;
        kept_next.conf  = cand.conf;
        kept_next.src   = cand.src;
        if (kept.index != INDEX_MAX) begin
          kept_next.index = kept.index + INDEX_WIDTH'(1);
        end
      end
    end
  end

endmodule

// ----- sv/slice_marker_spacing_merge_core.sv -----
`timescale 1ns / 1ps
// Top level of the slice marker spacing merge block: input register, kept
// marker state, result register and configuration registers. Uses smm_pkg, smm_merge.
//
// Usage:
//   The slave stream (s_tvalid/s_tready/s_tdata/s_tuser) carries one item per
//   transfer: either a marker candidate (s_tuser = 0) or a finish command
//   (s_tuser = 1). Candidates arrive sorted by frame.
//   The master stream (m_tvalid/m_tready/m_tdata/m_tlast) carries slice
//   regions. m_tlast marks the final region of a map, sent on finish.
//   The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   the minimum spacing (index 0) and the source length (index 1); it is
//   always ready and should only be used while the block is idle.
// Timing:
//   An accepted item lands in the input register and is evaluated against the
//   kept marker there once the result register can take its region; if it
//   closes a region, that region is registered and appears on the master side.
//   One item per cycle is sustained while m_tready stays high; the limit is the
//   compare, subtract and kept-marker update done in the evaluation cycle.
// Reset and stalls:
//   rst clears the valid flags, restores the origin marker (frame 0, confidence
//   1.0, manual source, index 0) and sets the spacing to 0 and the length to 1.
//   When m_tready is low with a region pending, the input register still fills,
//   and s_tready then drops until the region goes.
module slice_marker_spacing_merge_core (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration write channel.
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [smm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [smm_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  // Input stream.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // s_tdata, low bit up: cand_frame[31:0], cand_confidence[47:32],
  // cand_source[50:48], cand_valid[51], zero pad[55:52].
  input  logic [smm_pkg::IN_DATA_WIDTH-1:0]     s_tdata,
  // s_tuser: cmd (0 candidate, 1 finish).
  input  logic                                  s_tuser,
  // Output stream.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata, low bit up: region_start[31:0], region_end[63:32],
  // region_marker[95:64], region_confidence[111:96], region_source[114:112],
  // zero pad[119:115].
  output logic [smm_pkg::OUT_DATA_WIDTH-1:0]    m_tdata,
  // m_tlast: map_done.
  output logic                                  m_tlast
);
  import smm_pkg::*;

  logic [FRAME_WIDTH-1:0] min_gap;
  logic [FRAME_WIDTH-1:0] source_length;

  cand_t   cand;
  logic    cand_full;
  kept_t   kept;
  kept_t   kept_next;
  region_t region;
  region_t region_next;
  logic    emit;
  logic    advance;

  // Configuration registers. Writes are never stalled.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap       <= '0;
      source_length <= FRAME_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_SPACING:   min_gap       <= FRAME_WIDTH'(cfg_data);
        REG_SOURCE_LENGTH: source_length <= FRAME_WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  // The held item moves on once the result register can take its region,
  // whether or not it produces one.
  assign advance  = cand_full && (!m_tvalid || m_tready);
  assign s_tready = !cand_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_full <= 1'b0;
    end else if (s_tready) begin
      cand_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cand.cmd   <= s_tuser;
      cand.frame <= s_tdata[FRAME_WIDTH-1:0];
      cand.conf  <= s_tdata[FRAME_WIDTH +: CONF_WIDTH];
      cand.src   <= s_tdata[FRAME_WIDTH + CONF_WIDTH +: SRC_WIDTH];
      cand.valid <= s_tdata[FRAME_WIDTH + CONF_WIDTH + SRC_WIDTH];
    end
  end

  smm_merge u_merge (
    .cand          (cand),
    .kept          (kept),
    .min_gap       (min_gap),
    .source_length (source_length),
    .kept_next     (kept_next),
    .emit          (emit),
    .region        (region_next)
  );

  // The kept marker changes in the same cycle its item is evaluated, so the
  // next item in the input register always sees the updated marker.
  always_ff @(posedge clk) begin
    if (rst) begin
      kept <= KEPT_ORIGIN;
    end else if (advance) begin
      kept <= kept_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      region <= region_next;
    end
  end

  assign m_tdata = OUT_DATA_WIDTH'({region.src, region.conf, region.marker,
                                    region.close_frame, region.open_frame});
  assign m_tlast = region.done;

  // A free result register must never hold back the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("s_tready low while the result register is empty");

  // Only accepted markers advance the index, and they never sit at frame 0.
  a_index_needs_frame: assert property (@(posedge clk) disable iff (rst)
    kept.index != '0 |-> kept.frame != '0)
    else $error("marker index advanced while the origin marker is kept");

  // Every emitted region is non-empty.
  a_region_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> region.open_frame < region.close_frame)
    else $error("empty region emitted");

  // Reset restores the origin marker.
  a_reset_origin: assert property (@(posedge clk)
    rst |=> kept == KEPT_ORIGIN)
    else $error("kept marker not restored by reset");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for slice_marker_spacing_merge_core: a directed table and a random
// stream of marker candidates, checked against a cycle-free model of the merge.
// Depends on smm_pkg and the core RTL only.
module tb_top;
  import smm_pkg::*;

  // Time the block needs to settle after the last region before a register write.
  localparam int SETTLE_CYCLES = 6;
  // Watchdog bound, many times the slowest legal run of this stimulus.
  localparam int CYCLE_LIMIT = 400000;
  // Items offered per random chunk.
  localparam int CHUNK_ITEMS = 115;
  localparam int HOLD_OFF_CYCLES = 80;

  typedef enum {ROW_SETUP, ROW_PREDICT, ROW_TYPED} row_kind_t;

  // One line of the directed table. A setup row carries the spacing in item.frame
  // and the source length in setup_length. A typed row carries its result by hand.
  typedef struct {
    row_kind_t   kind;
    cand_t       item;
    logic [31:0] setup_length;
    bit          typed_emit;
    region_t     typed;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_MIN_SPACING;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_WIDTH-1:0] s_tdata  = '0;
  logic                     s_tuser  = CMD_CANDIDATE;

  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_tdata;
  logic                      m_tlast;

  // Model copy of the block's registers and kept marker.
  logic [31:0] spacing_reg = '0;
  logic [31:0] length_reg  = 32'd1;
  kept_t       kept_marker = KEPT_ORIGIN;

  region_t pending_regions[$];
  row_t    directed_rows[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  cycles = 0;

  // Register settings visited by the random part, extremes included.
  logic [31:0] spacing_set [0:7] = '{32'd0, 32'd0, 32'd16, 32'hFFFF_FFFF,
                                     32'd300, 32'd3, 32'd1, 32'd64};
  logic [31:0] length_set  [0:7] = '{32'd1, 32'hFFFF_FFFF, 32'd4096, 32'hFFFF_FFFF,
                                     32'd20000, 32'd200, 32'd64, 32'd2000};

  slice_marker_spacing_merge_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #2 clk = ~clk;

  // Ranking of where a marker came from; an unused code ranks lowest.
  function automatic int trust_rank(input logic [SRC_WIDTH-1:0] s);
    case (s)
      SRC_LOOP_START, SRC_LOOP_END: return 5;
      SRC_MANUAL, SRC_IMPORTED:     return 4;
      SRC_BEAT_GRID:                return 3;
      SRC_SILENCE:                  return 2;
      SRC_ONSET:                    return 1;
      default:                      return 0;
    endcase
  endfunction

  function automatic region_t region_of(input logic [31:0] open_frame,
                                        input logic [31:0] close_frame,
                                        input logic [31:0] marker,
                                        input logic [15:0] conf,
                                        input logic [2:0] src,
                                        input logic done);
    region_t r;
    r.open_frame  = open_frame;
    r.close_frame = close_frame;
    r.marker      = marker;
    r.conf        = conf;
    r.src         = src;
    r.done        = done;
    return r;
  endfunction

  // Advances the kept marker by one accepted item and yields the region it closes,
  // if any.
  task automatic merge_step(input cand_t c, output bit emits, output region_t r);
    logic [FRAME_WIDTH-1:0] gap;
    bit better;
    emits  = 1'b0;
    better = 1'b0;
    r      = '0;
    gap    = c.frame - kept_marker.frame;
    if (c.cmd == CMD_FINISH) begin
      if (length_reg > kept_marker.frame) begin
        emits = 1'b1;
        r = region_of(kept_marker.frame, length_reg, kept_marker.index,
                      kept_marker.conf, kept_marker.src, 1'b1);
      end
      kept_marker = KEPT_ORIGIN;
    end else if (!c.valid || c.frame == '0 || c.frame >= length_reg) begin
      // Dropped: the state stays as it was.
    end else if (gap < spacing_reg) begin
      // Too close: the origin is never displaced, anything else only by a better marker.
      if (kept_marker.frame != '0) begin
        if (c.conf != kept_marker.conf)
          better = c.conf > kept_marker.conf;
        else
          better = trust_rank(c.src) > trust_rank(kept_marker.src);
        if (better) begin
          kept_marker.frame = c.frame;
          kept_marker.conf  = c.conf;
          kept_marker.src   = c.src;
        end
      end
    end else begin
      // Far enough (a frame behind the kept one wraps and counts as far).
      if (c.frame > kept_marker.frame) begin
        emits = 1'b1;
        r = region_of(kept_marker.frame, c.frame, kept_marker.index,
                      kept_marker.conf, kept_marker.src, 1'b0);
      end
      kept_marker.frame = c.frame;
      kept_marker.conf  = c.conf;
      kept_marker.src   = c.src;
      if (kept_marker.index != INDEX_MAX)
        kept_marker.index = kept_marker.index + 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100)
      $display("%0t ns: region %s got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offers one item after a random gap and waits for the handshake. The model
  // runs at the accepting edge; a typed row replaces the model's result.
  task automatic push_item(input cand_t c, input bit typed, input bit typed_emit,
                           input region_t typed_region);
    bit      emits;
    region_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.cmd;
    s_tdata  <= {4'b0000, c.valid, c.src, c.conf, c.frame};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    merge_step(c, emits, r);
    if (typed) begin
      emits = typed_emit;
      r     = typed_region;
    end
    if (emits) pending_regions.insert(pending_regions.size(), r);
  endtask

  // Stops offering, waits for every expected region, then lets the pipeline empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; valid stays high between the two writes.
  task automatic write_regs(input logic [31:0] spacing, input logic [31:0] length);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MIN_SPACING;
    cfg_data  <= spacing;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    spacing_reg = spacing;
    cfg_index <= REG_SOURCE_LENGTH;
    cfg_data  <= length;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    length_reg = length;
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(input row_kind_t kind, input cmd_t cmd,
                                  input logic [31:0] frame, input logic [15:0] conf,
                                  input logic [2:0] src, input logic valid,
                                  input logic [31:0] setup_length, input bit typed_emit,
                                  input region_t typed);
    row_t row;
    row.kind         = kind;
    row.item.cmd     = cmd;
    row.item.frame   = frame;
    row.item.conf    = conf;
    row.item.src     = src;
    row.item.valid   = valid;
    row.setup_length = setup_length;
    row.typed_emit   = typed_emit;
    row.typed        = typed;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Mostly sorted candidates that step from the kept marker by amounts around the
  // spacing, with confidence ties; the rest are finishes, noise and dropped frames.
  function automatic cand_t random_item();
    cand_t c;
    longint unsigned step;
    longint unsigned f;
    int roll;
    c.cmd   = CMD_CANDIDATE;
    c.frame = $urandom;
    c.conf  = 16'($urandom);
    c.src   = 3'($urandom_range(0, 7));
    c.valid = ($urandom_range(0, 19) != 0);
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      c.cmd = CMD_FINISH;
    end else if (roll < 14) begin
      c.valid = 1'($urandom_range(0, 1));
    end else if (roll < 18) begin
      if ($urandom_range(0, 1) == 0) begin
        c.frame = '0;
      end else begin
        f = longint'(length_reg) + $urandom_range(0, 3);
        c.frame = (f > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : f[31:0];
      end
    end else begin
      case ($urandom_range(0, 5))
        0:       step = 0;
        1:       step = $urandom_range(0, spacing_reg);
        2:       step = (spacing_reg == 0) ? 0 : longint'(spacing_reg) - 1;
        3:       step = spacing_reg;
        4:       step = longint'(spacing_reg) + 1;
        default: step = $urandom_range(0, length_reg >> 2);
      endcase
      f = longint'(kept_marker.frame) + step;
      // Running off the end of the source closes the map.
      if (f >= longint'(length_reg))
        c.cmd = CMD_FINISH;
      else
        c.frame = f[31:0];
      case ($urandom_range(0, 3))
        0:       c.conf = kept_marker.conf;
        1:       c.conf = CONF_ONE;
        2:       c.conf = 16'($urandom_range(0, 15)) << 12;
        default: c.conf = 16'($urandom);
      endcase
    end
    return c;
  endfunction

  // Receiver side: checks each region at its accepting edge, then picks the next
  // ready value. A hold-off request keeps ready low for a long stretch.
  always @(posedge clk) begin : region_check
    region_t got;
    region_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.open_frame  = m_tdata[31:0];
      got.close_frame = m_tdata[63:32];
      got.marker      = m_tdata[95:64];
      got.conf        = m_tdata[111:96];
      got.src         = m_tdata[114:112];
      got.done        = m_tlast;
      if (pending_regions.size() == 0) begin
        report_mismatch("without expectation, start", got.open_frame, '0);
      end else begin
        want = pending_regions.pop_front();
        if (got.open_frame != want.open_frame)
          report_mismatch("start", got.open_frame, want.open_frame);
        if (got.close_frame != want.close_frame)
          report_mismatch("end", got.close_frame, want.close_frame);
        if (got.marker != want.marker)
          report_mismatch("marker", got.marker, want.marker);
        if (got.conf != want.conf)
          report_mismatch("confidence", 32'(got.conf), 32'(want.conf));
        if (got.src != want.src)
          report_mismatch("source", 32'(got.src), 32'(want.src));
        if (got.done != want.done)
          report_mismatch("map_done", 32'(got.done), 32'(want.done));
      end
    end
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    row_t row;
    int   offered;
    int   pick;

    // Directed table. Typed rows are the ones whose result is plain from the
    // origin marker or from a drop; the rest go through the model.
    add_row(ROW_TYPED, CMD_FINISH, 0, 0, 0, 0, 0, 1'b1,
            region_of(0, 1, 0, CONF_ONE, SRC_MANUAL, 1'b1));
    add_row(ROW_TYPED, CMD_CANDIDATE, 1, 16'h2000, SRC_ONSET, 1, 0, 1'b0, '0);
    add_row(ROW_SETUP, CMD_CANDIDATE, 10, 0, 0, 0, 1000, 1'b0, '0);
    // Dropped: invalid, frame zero, frame at the source length.
    add_row(ROW_TYPED, CMD_CANDIDATE, 50, 16'h2000, SRC_ONSET, 0, 0, 1'b0, '0);
    add_row(ROW_TYPED, CMD_CANDIDATE, 0, 16'h2000, SRC_ONSET, 1, 0, 1'b0, '0);
    add_row(ROW_TYPED, CMD_CANDIDATE, 1000, 16'h2000, SRC_ONSET, 1, 0, 1'b0, '0);
    // Close to the origin: never replaces it, however good.
    add_row(ROW_TYPED, CMD_CANDIDATE, 5, 16'hFFFF, SRC_LOOP_START, 1, 0, 1'b0, '0);
    add_row(ROW_TYPED, CMD_CANDIDATE, 100, 16'h2000, SRC_ONSET, 1, 0, 1'b1,
            region_of(0, 100, 0, CONF_ONE, SRC_MANUAL, 1'b0));
    // Close: equal confidence with better source, then worse source, then higher
    // confidence with the unused code, then lower confidence.
    add_row(ROW_PREDICT, CMD_CANDIDATE, 105, 16'h2000, SRC_BEAT_GRID, 1, 0, 1'b0, '0);
    add_row(ROW_PREDICT, CMD_CANDIDATE, 106, 16'h2000, SRC_SILENCE, 1, 0, 1'b0, '0);
    add_row(ROW_PREDICT, CMD_CANDIDATE, 107, 16'h3000, 3'd7, 1, 0, 1'b0, '0);
    add_row(ROW_PREDICT, CMD_CANDIDATE, 108, 16'h0000, SRC_LOOP_END, 1, 0, 1'b0, '0);
    add_row(ROW_PREDICT, CMD_CANDIDATE, 120, 16'h1000, SRC_IMPORTED, 1, 0, 1'b0, '0);
    // Exactly the spacing away counts as far.
    add_row(ROW_PREDICT, CMD_CANDIDATE, 130, 16'h1800, SRC_MANUAL, 1, 0, 1'b0, '0);
    // Behind the kept marker: wraps to far, empty region, index still advances.
    add_row(ROW_PREDICT, CMD_CANDIDATE, 50, 16'h0800, SRC_SILENCE, 1, 0, 1'b0, '0);
    add_row(ROW_PREDICT, CMD_CANDIDATE, 60, 16'h0900, SRC_ONSET, 1, 0, 1'b0, '0);
    // Finish ignores whatever the candidate fields hold.
    add_row(ROW_PREDICT, CMD_FINISH, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 1, 0, 1'b0, '0);
    add_row(ROW_SETUP, CMD_CANDIDATE, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(ROW_TYPED, CMD_CANDIDATE, 32'hFFFF_FFFE, 16'hFFFF, SRC_ONSET, 1, 0, 1'b1,
            region_of(0, 32'hFFFF_FFFE, 0, CONF_ONE, SRC_MANUAL, 1'b0));
    add_row(ROW_TYPED, CMD_CANDIDATE, 32'hFFFF_FFFF, 16'h0000, SRC_LOOP_START, 1, 0,
            1'b0, '0);
    // Same frame again with zero spacing: accepted, but the region is empty.
    add_row(ROW_PREDICT, CMD_CANDIDATE, 32'hFFFF_FFFE, 16'h0001, SRC_MANUAL, 1, 0,
            1'b0, '0);
    add_row(ROW_PREDICT, CMD_FINISH, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(ROW_PREDICT, CMD_CANDIDATE, 500, 16'h8000, SRC_BEAT_GRID, 1, 0, 1'b0, '0);
    // Shrink the source below the kept marker without finishing the map.
    add_row(ROW_SETUP, CMD_CANDIDATE, 32'hFFFF_FFFF, 0, 0, 0, 300, 1'b0, '0);
    add_row(ROW_TYPED, CMD_CANDIDATE, 600, 16'hFFFF, SRC_LOOP_START, 1, 0, 1'b0, '0);
    add_row(ROW_PREDICT, CMD_CANDIDATE, 200, 16'h0000, SRC_LOOP_START, 1, 0, 1'b0, '0);
    // Finish with an empty final region, then a finish from the origin.
    add_row(ROW_TYPED, CMD_FINISH, 0, 0, 0, 0, 0, 1'b0, '0);
    add_row(ROW_TYPED, CMD_FINISH, 0, 0, 0, 0, 0, 1'b1,
            region_of(0, 300, 0, CONF_ONE, SRC_MANUAL, 1'b1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 27;
    recv_idle_pct = 71;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_SETUP) begin
        settle();
        write_regs(row.item.frame, row.setup_length);
      end else begin
        push_item(row.item, row.kind == ROW_TYPED, row.typed_emit, row.typed);
      end
    end

    // Random part: three idling modes, four register settings each. The kept
    // marker carries over a register change, as the block's does.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 4; k++) begin
        settle();
        pick = (p * 4 + k) % 8;
        write_regs(spacing_set[pick], length_set[pick]);
        // The receiver holds off while the sender keeps offering, so the block
        // backs up and stalls its input.
        if (k == 1) hold_req = 1'b1;
        offered = 0;
        while (offered < CHUNK_ITEMS) begin
          // The sender pauses once per mode until every region is back.
          if (k == 2 && offered == 60) settle();
          push_item(random_item(), 1'b0, 1'b0, '0);
          offered++;
        end
      end
    end

    settle();
    if (mismatches == 0 && pending_regions.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
